// ----- sv/mlgr_pkg.sv -----
// ----------------------------------------------------------------------------
// mlgr_pkg
// Shared constants, request codes and slot mapping for the multiplexed LED
// grayscale refresh block.
// ----------------------------------------------------------------------------
package mlgr_pkg;

	localparam int CHIPS_DEF      = 2;
	localparam int ROWS_DEF       = 4;
	localparam int GROUP_CHANNELS = 8;
	localparam int COLORS         = 3;
	localparam int SLOTS          = GROUP_CHANNELS * COLORS;
	localparam int SLOT_W         = $clog2(SLOTS);
	localparam int CHAN_W         = $clog2(GROUP_CHANNELS);
	localparam int GRAY_W         = 12;
	localparam int SEL_W          = 4;

	localparam logic [2:0] REQ_WRITE = 3'd0;
	localparam logic [2:0] REQ_READ  = 3'd1;
	localparam logic [2:0] REQ_SWAP  = 3'd2;
	localparam logic [2:0] REQ_SCAN  = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;

	localparam logic [1:0] COLOR_BLUE   = 2'd0;
	localparam logic [1:0] COLOR_UNUSED = 2'd3;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_SCAN = 1'b1;

	// slot = (7 - chan) * 3 + color, unused colour code maps to blue
	function automatic logic [SLOT_W-1:0] slot_of(input logic [1:0] color,
			input logic [CHAN_W-1:0] chan);
		logic [1:0]        c;
		logic [SLOT_W-1:0] g;
		c = (color == COLOR_UNUSED) ? COLOR_BLUE : color;
		g = SLOT_W'(CHAN_W'(GROUP_CHANNELS - 1) - chan);
		return SLOT_W'(g * SLOT_W'(COLORS)) + SLOT_W'(c);
	endfunction

endpackage

// ----- sv/mlgr_mem.sv -----
// ----------------------------------------------------------------------------
// mlgr_mem
// Grayscale store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mlgr_mem import mlgr_pkg::*; #(
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [GRAY_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [GRAY_W-1:0] rdata
);

	logic [GRAY_W-1:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/mlgr_ctrl.sv -----
// ----------------------------------------------------------------------------
// mlgr_ctrl
// Request decode, buffer select, scan row, burst and clear sequencing, and
// the result stage aligned to the store's read latency.
// ----------------------------------------------------------------------------
module mlgr_ctrl import mlgr_pkg::*; #(
	parameter int CHIPS  = CHIPS_DEF,
	parameter int ROWS   = ROWS_DEF,
	parameter int ROW_W  = 2,
	parameter int POS_W  = 1,
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        req_type,
	input  logic              chip,
	input  logic [1:0]        color,
	input  logic [2:0]        chan,
	input  logic [1:0]        row,
	input  logic [GRAY_W-1:0] level,
	input  logic              cfg_we,
	input  logic              cfg_data,
	output logic              mem_we,
	output logic [ADDR_W-1:0] mem_waddr,
	output logic [GRAY_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [ADDR_W-1:0] mem_raddr,
	input  logic [GRAY_W-1:0] mem_rdata,
	output logic              strobe,
	output logic              kind,
	output logic [GRAY_W-1:0] gray,
	output logic [SEL_W-1:0]  row_onehot,
	output logic              last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_BURST = 2'd2;

	localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(CHIPS - 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);

	logic [1:0]        state_q;
	logic              front_q;
	logic              mode_q;
	logic [ROW_W-1:0]  scan_row_q;
	logic [ROW_W-1:0]  nxt_row_q;
	logic [POS_W-1:0]  pos_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ADDR_W-1:0] clr_q;

	logic              valid_s1;
	logic              kind_s1;
	logic              last_s1;
	logic              zero_s1;
	logic [SEL_W-1:0]  sel_s1;

	logic              accept;
	logic              chip_ok;
	logic              row_ok;
	logic [POS_W-1:0]  pos_in;
	logic [SLOT_W-1:0] slot_in;
	logic [ROW_W-1:0]  row_adv;
	logic [ROW_W-1:0]  row_adv2;
	logic              burst_end;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign chip_ok = (CHIPS > 1) || (chip == 1'b0);
	assign row_ok  = ({1'b0, row} < 3'(ROWS));
	assign pos_in  = POS_LAST - POS_W'(chip);
	assign slot_in = slot_of(color, chan);
	assign row_adv  = (scan_row_q == ROW_LAST) ? '0 : scan_row_q + 1'b1;
	assign row_adv2 = (row_adv == ROW_LAST) ? '0 : row_adv + 1'b1;
	assign burst_end = (pos_q == POS_LAST) && (slot_q == SLOT_LAST);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (accept && req_type == REQ_WRITE && chip_ok && row_ok) begin
			mem_we    = 1'b1;
			mem_waddr = {~front_q, row[ROW_W-1:0], pos_in, slot_in};
			mem_wdata = level;
		end
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = {~front_q, scan_row_q, pos_in, slot_in};
		if (state_q == ST_BURST) begin
			mem_re    = 1'b1;
			mem_raddr = {front_q, nxt_row_q, pos_q, slot_q};
		end else if (accept && req_type == REQ_READ) begin
			mem_re = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			front_q    <= 1'b0;
			mode_q     <= 1'b0;
			scan_row_q <= '0;
			nxt_row_q  <= '0;
			pos_q      <= '0;
			slot_q     <= '0;
			clr_q      <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_SWAP: begin
								front_q <= ~front_q;
							end
							REQ_SCAN: begin
								scan_row_q <= row_adv;
								nxt_row_q  <= row_adv2;
								pos_q      <= mode_q ? POS_LAST : '0;
								slot_q     <= '0;
								state_q    <= ST_BURST;
							end
							REQ_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_BURST: begin
					if (burst_end) begin
						state_q <= ST_IDLE;
					end else if (slot_q == SLOT_LAST) begin
						slot_q <= '0;
						pos_q  <= pos_q + 1'b1;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_BURST) begin
			kind_s1 <= KIND_SCAN;
			last_s1 <= burst_end;
			zero_s1 <= 1'b0;
			sel_s1  <= SEL_W'(1) << scan_row_q;
		end else begin
			kind_s1 <= KIND_READ;
			last_s1 <= 1'b1;
			zero_s1 <= !chip_ok;
			sel_s1  <= SEL_W'(1) << scan_row_q;
		end
	end

	assign strobe     = valid_s1;
	assign kind       = kind_s1;
	assign gray       = zero_s1 ? '0 : mem_rdata;
	assign row_onehot = sel_s1;
	assign last       = last_s1;

endmodule

// ----- sv/multiplexed_led_grayscale_refresh.sv -----
// ----------------------------------------------------------------------------
// multiplexed_led_grayscale_refresh
// Double-buffered grayscale store for chained 24-slot LED drivers scanned
// over multiplexed rows.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low. Writes, reads and swaps
// leave busy low and may follow back to back; a read result appears on the
// cycle after the request, marked by strobe. A scan tick holds busy while the
// sequencer reads every chip's slots (one chip's in single-chip mode) one word
// a cycle from the store's single read port; the words follow, registered,
// one per cycle, last set on the final one. After reset and after a clear
// request busy stays high while the store is zeroed one word a cycle;
// configuration writes are taken throughout. Results cannot be held off: each
// is valid for exactly one cycle with strobe.
module multiplexed_led_grayscale_refresh import mlgr_pkg::*; #(
	parameter int CHIPS = CHIPS_DEF,
	parameter int ROWS  = ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        req_type,
	input  logic              chip,
	input  logic [1:0]        color,
	input  logic [2:0]        chan,
	input  logic [1:0]        row,
	input  logic [GRAY_W-1:0] level,
	input  logic              cfg_we,
	input  logic              cfg_data,
	output logic              strobe,
	output logic              kind,
	output logic [GRAY_W-1:0] gray,
	output logic [SEL_W-1:0]  row_onehot,
	output logic              last
);

	localparam int ROW_W  = $clog2(ROWS);
	localparam int POS_W  = (CHIPS > 1) ? $clog2(CHIPS) : 1;
	localparam int ADDR_W = 1 + ROW_W + POS_W + SLOT_W;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [GRAY_W-1:0] mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [GRAY_W-1:0] mem_rdata;

	mlgr_ctrl #(
		.CHIPS  (CHIPS),
		.ROWS   (ROWS),
		.ROW_W  (ROW_W),
		.POS_W  (POS_W),
		.ADDR_W (ADDR_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.chip       (chip),
		.color      (color),
		.chan       (chan),
		.row        (row),
		.level      (level),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.strobe     (strobe),
		.kind       (kind),
		.gray       (gray),
		.row_onehot (row_onehot),
		.last       (last)
	);

	mlgr_mem #(
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
